/* design/assert_macros.svh */
// assertion helpers shared by the queue modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is held
`define DCEQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also runs during reset
`define DCEQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* design/dceq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dceq_pkg
// Shared types, codes and constants of the debounced coalescing event queue.
// ----------------------------------------------------------------------------
package dceq_pkg;

  // default sizes
  localparam int DEPTH_DEF = 64;
  localparam int KEY_W_DEF = 32;

  // field widths
  localparam int OP_W       = 2;
  localparam int PATH_KEY_W = 32;
  localparam int KIND_W     = 2;
  localparam int TIME_W     = 48;
  localparam int DEB_W      = 32;
  localparam int MAXQ_W     = 7;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXQ     = 2'd2;

  // register reset values
  localparam logic              ENABLE_RST   = 1'b1;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 32'd100;
  localparam logic [MAXQ_W-1:0] MAXQ_RST     = 7'd0;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT = 2'd0,
    OP_POLL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED     = 3'd0,
    ST_MERGED     = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_IGNORED    = 3'd3,
    ST_RELEASED   = 3'd4,
    ST_NONE_READY = 3'd5,
    ST_CLEARED    = 3'd6
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    start_scan;
    logic    scan_step;
    logic    merge_wr;
    logic    append;
    logic    clear_q;
    logic    head_rd;
    logic    pop;
    logic    hold_ld;
    logic    out_ld;
    logic    out_hold;
    logic    out_final;
    status_t status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic enable;
    logic deb_nz;
    logic q_empty;
    logic q_full;
    logic match;
    logic scan_end;
    logic expired;
    logic out_free;
  } sts_t;

endpackage

/* design/dceq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dceq_ctrl
// Sequencer for the queue: dispatches each item, walks the merge search and
// the poll release, and schedules every result beat into the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dceq_ctrl
  import dceq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DISPATCH  = 9'b000000010,
    S_SEARCH    = 9'b000000100,
    S_APPEND    = 9'b000001000,
    S_FINISH    = 9'b000010000,
    S_POLL_RD   = 9'b000100000,
    S_POLL_CHK  = 9'b001000000,
    S_POLL_EMIT = 9'b010000000,
    S_POLL_LAST = 9'b100000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t stat_r, stat_nxt;
  logic    hold_v_r, hold_v_nxt;

  // state, pending status and held-release flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      stat_r   <= ST_QUEUED;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stat_r   <= stat_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    stat_nxt   = stat_r;
    hold_v_nxt = hold_v_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_EVENT: begin
            if (!sts.enable) begin
              stat_nxt  = ST_IGNORED;
              state_nxt = S_FINISH;
            end else if (sts.deb_nz && !sts.q_empty) begin
              cmd.start_scan = 1'b1;
              state_nxt      = S_SEARCH;
            end else begin
              state_nxt = S_APPEND;
            end
          end
          OP_POLL: begin
            hold_v_nxt = 1'b0;
            state_nxt  = S_POLL_RD;
          end
          OP_CLEAR: begin
            cmd.clear_q = 1'b1;
            stat_nxt    = ST_CLEARED;
            state_nxt   = S_FINISH;
          end
          default: begin
            stat_nxt  = ST_IGNORED;
            state_nxt = S_FINISH;
          end
        endcase
      end
      // newest to oldest, one compare per cycle
      S_SEARCH: begin
        if (sts.match) begin
          cmd.merge_wr = 1'b1;
          stat_nxt     = ST_MERGED;
          state_nxt    = S_FINISH;
        end else if (sts.scan_end) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        stat_nxt   = sts.q_full ? ST_DROPPED : ST_QUEUED;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_final = 1'b1;
          cmd.status    = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      // poll: read head, then decide once its deadline is known
      S_POLL_RD: begin
        if (sts.q_empty) begin
          if (hold_v_r) begin
            state_nxt = S_POLL_LAST;
          end else begin
            stat_nxt  = ST_NONE_READY;
            state_nxt = S_FINISH;
          end
        end else begin
          cmd.head_rd = 1'b1;
          state_nxt   = S_POLL_CHK;
        end
      end
      S_POLL_CHK: begin
        if (sts.expired) begin
          if (hold_v_r) begin
            state_nxt = S_POLL_EMIT;
          end else begin
            cmd.hold_ld = 1'b1;
            cmd.pop     = 1'b1;
            hold_v_nxt  = 1'b1;
            state_nxt   = S_POLL_RD;
          end
        end else if (hold_v_r) begin
          state_nxt = S_POLL_LAST;
        end else begin
          stat_nxt  = ST_NONE_READY;
          state_nxt = S_FINISH;
        end
      end
      // another release follows, so this one is not final
      S_POLL_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_hold = 1'b1;
          cmd.status   = ST_RELEASED;
          hold_v_nxt   = 1'b0;
          state_nxt    = S_POLL_CHK;
        end
      end
      S_POLL_LAST: begin
        if (sts.out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_hold  = 1'b1;
          cmd.out_final = 1'b1;
          cmd.status    = ST_RELEASED;
          hold_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // checks
  `DCEQ_ASSERT(a_accept_dispatch, (state_r == S_IDLE && in_valid) |=> (state_r == S_DISPATCH), "accepted item not dispatched")
  `DCEQ_ASSERT(a_load_when_free, cmd.out_ld |-> sts.out_free, "output stage overwritten")
  `DCEQ_ASSERT(a_hold_in_poll, hold_v_r |-> (state_r == S_POLL_RD || state_r == S_POLL_CHK || state_r == S_POLL_EMIT || state_r == S_POLL_LAST), "held release outside poll")

endmodule

/* design/dceq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dceq_dpath
// Queue datapath: config registers, item latch, ring memory with one write
// and one registered read port, ring pointers, release hold and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dceq_dpath
  import dceq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       in_op,
  input  logic [PATH_KEY_W-1:0] in_path_key,
  input  logic [PATH_KEY_W-1:0] in_old_path_key,
  input  logic [KIND_W-1:0]     in_event_kind,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [PATH_KEY_W-1:0] out_path_key,
  output logic [PATH_KEY_W-1:0] out_old_path_key,
  output logic [KIND_W-1:0]     out_kind,
  output logic [TIME_W-1:0]     out_time,
  output logic                  out_final_of_run,
  output logic [MAXQ_W-1:0]     out_queued_count
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [MAXQ_W-1:0] DEPTH_MQ  = MAXQ_W'(DEPTH);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  // config registers
  logic              enable_r;
  logic [DEB_W-1:0]  debounce_r;
  logic [MAXQ_W-1:0] maxq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= ENABLE_RST;
      debounce_r <= DEBOUNCE_RST;
      maxq_r     <= MAXQ_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE:   enable_r   <= cfg_data[0];
        CFG_DEBOUNCE: debounce_r <= cfg_data[DEB_W-1:0];
        CFG_MAXQ:     maxq_r     <= cfg_data[MAXQ_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating deadline of the incoming item
  logic [TIME_W:0]   dl_sum;
  logic [TIME_W-1:0] dl_sat;

  assign dl_sum = {1'b0, in_now_ms} + (TIME_W + 1)'(debounce_r);
  assign dl_sat = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

  // item latch
  op_t                 op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] old_r;
  logic [KIND_W-1:0]   kind_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   dl_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_op);
      key_r  <= KEY_WIDTH'(in_path_key);
      old_r  <= KEY_WIDTH'(in_old_path_key);
      kind_r <= in_event_kind;
      now_r  <= in_now_ms;
      dl_r   <= dl_sat;
    end
  end

  // ring pointers and fill
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [MAXQ_W-1:0] limit;
  logic              q_full;

  assign limit  = (maxq_r == '0 || maxq_r >= DEPTH_MQ) ? DEPTH_MQ : maxq_r;
  assign q_full = (MAXQ_W'(total_r) >= limit) && (total_r != '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    total_nxt = total_r;
    if (cmd.clear_q) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      total_nxt = '0;
    end else if (cmd.append) begin
      tail_nxt = next_slot(tail_r);
      if (q_full) begin
        head_nxt = next_slot(head_r);
      end else begin
        total_nxt = total_r + 1'b1;
      end
    end else if (cmd.pop) begin
      head_nxt  = next_slot(head_r);
      total_nxt = total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      total_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
    end
  end

  // merge scan walker
  logic [SLOT_W-1:0] scan_slot_r;
  logic [CNT_W-1:0]  scan_left_r;
  logic              pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_slot_r <= '0;
      scan_left_r <= '0;
      pend_r      <= 1'b0;
    end else if (cmd.start_scan) begin
      scan_slot_r <= prev_slot(tail_r);
      scan_left_r <= total_r;
      pend_r      <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_slot_r <= prev_slot(scan_slot_r);
      scan_left_r <= scan_left_r - 1'b1;
      pend_r      <= 1'b1;
    end
  end

  // ring memory
  logic [KEY_WIDTH-1:0] mem_key [DEPTH];
  logic [KEY_WIDTH-1:0] mem_old [DEPTH];
  logic [KIND_W-1:0]    mem_kind [DEPTH];
  logic [TIME_W-1:0]    mem_time [DEPTH];
  logic [TIME_W-1:0]    mem_dl [DEPTH];

  logic                 rd_en;
  logic [SLOT_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]    wr_addr;
  logic [SLOT_W-1:0]    rd_slot_r;
  logic [KEY_WIDTH-1:0] rd_key_r;
  logic [KEY_WIDTH-1:0] rd_old_r;
  logic [KIND_W-1:0]    rd_kind_r;
  logic [TIME_W-1:0]    rd_time_r;
  logic [TIME_W-1:0]    rd_dl_r;

  assign rd_en   = cmd.scan_step || cmd.head_rd;
  assign rd_addr = cmd.head_rd ? head_r : scan_slot_r;
  assign wr_addr = cmd.merge_wr ? rd_slot_r : tail_r;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem_key[wr_addr] <= key_r;
      mem_old[wr_addr] <= old_r;
    end
    if (cmd.append || cmd.merge_wr) begin
      mem_kind[wr_addr] <= kind_r;
      mem_time[wr_addr] <= now_r;
      mem_dl[wr_addr]   <= dl_r;
    end
    if (rd_en) begin
      rd_slot_r <= rd_addr;
      rd_key_r  <= mem_key[rd_addr];
      rd_old_r  <= mem_old[rd_addr];
      rd_kind_r <= mem_kind[rd_addr];
      rd_time_r <= mem_time[rd_addr];
      rd_dl_r   <= mem_dl[rd_addr];
    end
  end

  // released entry waiting for its final flag
  logic [KEY_WIDTH-1:0] hold_key_r;
  logic [KEY_WIDTH-1:0] hold_old_r;
  logic [KIND_W-1:0]    hold_kind_r;
  logic [TIME_W-1:0]    hold_time_r;

  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      hold_key_r  <= rd_key_r;
      hold_old_r  <= rd_old_r;
      hold_kind_r <= rd_kind_r;
      hold_time_r <= rd_time_r;
    end
  end

  // output stage
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [PATH_KEY_W-1:0] out_key_r;
  logic [PATH_KEY_W-1:0] out_old_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [TIME_W-1:0]     out_time_r;
  logic                  out_final_r;
  logic [MAXQ_W-1:0]     out_count_r;
  logic                  out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r <= cmd.status;
      out_final_r  <= cmd.out_final;
      out_count_r  <= MAXQ_W'(total_r);
      if (cmd.out_hold) begin
        out_key_r  <= PATH_KEY_W'(hold_key_r);
        out_old_r  <= PATH_KEY_W'(hold_old_r);
        out_kind_r <= hold_kind_r;
        out_time_r <= hold_time_r;
      end else begin
        out_key_r  <= '0;
        out_old_r  <= '0;
        out_kind_r <= '0;
        out_time_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_path_key     = out_key_r;
  assign out_old_path_key = out_old_r;
  assign out_kind         = out_kind_r;
  assign out_time         = out_time_r;
  assign out_final_of_run = out_final_r;
  assign out_queued_count = out_count_r;

  // status to the controller
  always_comb begin
    sts          = '0;
    sts.op       = op_r;
    sts.enable   = enable_r;
    sts.deb_nz   = (debounce_r != '0);
    sts.q_empty  = (total_r == '0);
    sts.q_full   = q_full;
    sts.match    = pend_r && (rd_key_r == key_r);
    sts.scan_end = (scan_left_r == '0);
    sts.expired  = !(now_r < rd_dl_r);
    sts.out_free = out_free;
  end

  // checks
  `DCEQ_ASSERT(a_fill_bound, total_r <= DEPTH_CNT, "fill above depth")
  `DCEQ_ASSERT(a_ring_consistent, (int'(head_r) + int'(total_r) == int'(tail_r)) || (int'(head_r) + int'(total_r) == int'(tail_r) + DEPTH), "head fill and tail disagree")
  `DCEQ_ASSERT(a_blank_unless_released, (out_valid_r && out_status_r != ST_RELEASED) |-> (out_key_r == '0 && out_old_r == '0 && out_kind_r == '0 && out_time_r == '0), "payload on a non-release beat")

endmodule

/* design/debounced_coalescing_event_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_coalescing_event_queue_unit
// Ring queue of path change events with debounce merging and timed release.
//
// Channels: in_* takes one operation per beat (event, poll or clear); out_*
// returns result beats, one per event or clear, and one per released entry
// (or a single none-ready beat) per poll, the last carrying out_final_of_run.
// cfg_* writes enable, debounce_time and max_queued; cfg_ready is always high.
// With a nonzero debounce an event walks the queued keys newest to oldest
// through the single read port of the ring memory, then merges into the
// matching slot or appends; a clear or an ignored item goes straight to
// its result beat. A poll reads each head entry in turn until one is live.
// One item is in work at a time; in_ready rises again once the last result
// beat of the item sits in the output register.
// Reset: queue empty, enable 1, debounce 100 ms, limit = full depth. The ring
// memory is not cleared; only written slots are ever read.
// Stall: a held out_ready freezes the output register and the sequencer waits
// before loading the next beat; input is taken meanwhile when idle.
// ----------------------------------------------------------------------------
module debounced_coalescing_event_queue_unit
  import dceq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_op,
  input  logic [PATH_KEY_W-1:0] in_path_key,
  input  logic [PATH_KEY_W-1:0] in_old_path_key,
  input  logic [KIND_W-1:0]     in_event_kind,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [PATH_KEY_W-1:0] out_path_key,
  output logic [PATH_KEY_W-1:0] out_old_path_key,
  output logic [KIND_W-1:0]     out_kind,
  output logic [TIME_W-1:0]     out_time,
  output logic                  out_final_of_run,
  output logic [MAXQ_W-1:0]     out_queued_count
);

  cmd_t cmd;
  sts_t sts;

  // config writes always land
  assign cfg_ready = 1'b1;

  // sequencer
  dceq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and output stage
  dceq_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_path_key      (in_path_key),
    .in_old_path_key  (in_old_path_key),
    .in_event_kind    (in_event_kind),
    .in_now_ms        (in_now_ms),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_path_key     (out_path_key),
    .out_old_path_key (out_old_path_key),
    .out_kind         (out_kind),
    .out_time         (out_time),
    .out_final_of_run (out_final_of_run),
    .out_queued_count (out_queued_count)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debounced coalescing event queue unit.
//
// A scoreboard copy of the ring (keys, kinds, stamps, deadlines, head, tail,
// fill) and of the three registers predicts every result beat of each
// accepted operation. Directed tests walk merging, ordered release, deadline
// saturation, disabled input, the no-merge setting and the fill limit; then
// a full-ring wrap run and mixed random traffic under several settings.
// Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  import dceq_pkg::*;

  // op code outside the defined set
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_CREATED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MODIFIED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RENAMED  = 2'd3;

  localparam int RING_DEPTH = 64;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PATH_KEY_W-1:0] key;
    logic [PATH_KEY_W-1:0] old_key;
    logic [KIND_W-1:0]     kind;
    logic [TIME_W-1:0]     stamp;
    logic                  last;
    logic [MAXQ_W-1:0]     count;
  } queue_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op;
  logic [PATH_KEY_W-1:0] in_path_key;
  logic [PATH_KEY_W-1:0] in_old_path_key;
  logic [KIND_W-1:0]     in_event_kind;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [PATH_KEY_W-1:0] out_path_key;
  logic [PATH_KEY_W-1:0] out_old_path_key;
  logic [KIND_W-1:0]     out_kind;
  logic [TIME_W-1:0]     out_time;
  logic                  out_final_of_run;
  logic [MAXQ_W-1:0]     out_queued_count;

  // scoreboard copy of the ring and registers
  logic [PATH_KEY_W-1:0] ring_key      [RING_DEPTH];
  logic [PATH_KEY_W-1:0] ring_old_key  [RING_DEPTH];
  logic [KIND_W-1:0]     ring_kind     [RING_DEPTH];
  logic [TIME_W-1:0]     ring_stamp    [RING_DEPTH];
  logic [TIME_W-1:0]     ring_deadline [RING_DEPTH];
  logic [5:0]            ring_head;
  logic [5:0]            ring_tail;
  logic [MAXQ_W-1:0]     ring_fill;
  logic                  reg_enable;
  logic [DEB_W-1:0]      reg_debounce;
  logic [MAXQ_W-1:0]     reg_limit;

  queue_beat_t pending_results[$];
  queue_beat_t want_beat;
  queue_beat_t got_beat;
  int          err_count = 0;
  int          calm_left [2];
  int          ready_hold = 0;
  int          drain_guard;

  debounced_coalescing_event_queue_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_path_key      (in_path_key),
    .in_old_path_key  (in_old_path_key),
    .in_event_kind    (in_event_kind),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_path_key     (out_path_key),
    .out_old_path_key (out_old_path_key),
    .out_kind         (out_kind),
    .out_time         (out_time),
    .out_final_of_run (out_final_of_run),
    .out_queued_count (out_queued_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap(input logic side);
    int roll;
    if (calm_left[side] > 0) begin
      calm_left[side] = calm_left[side] - 1;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [TIME_W-1:0] rand_ms();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  // non-release beat with zeroed payload
  function automatic void add_status_beat(input logic [STATUS_W-1:0] status);
    queue_beat_t beat;
    beat.status  = status;
    beat.key     = '0;
    beat.old_key = '0;
    beat.kind    = '0;
    beat.stamp   = '0;
    beat.last    = 1'b1;
    beat.count   = ring_fill;
    pending_results.push_back(beat);
  endfunction

  // advance the ring copy by one operation and queue the beats it produces
  function automatic void predict_queue_results(input logic [OP_W-1:0] op,
                                                input logic [PATH_KEY_W-1:0] key,
                                                input logic [PATH_KEY_W-1:0] old_key,
                                                input logic [KIND_W-1:0] kind,
                                                input logic [TIME_W-1:0] now);
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   deadline;
    logic [5:0]          slot;
    logic [STATUS_W-1:0] status;
    int                  limit;
    int                  i;
    bit                  hit;
    bit                  released;
    queue_beat_t         beat;
    sum      = {1'b0, now} + {{(TIME_W + 1 - DEB_W){1'b0}}, reg_debounce};
    deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    limit    = (reg_limit == '0 || int'(reg_limit) >= RING_DEPTH) ? RING_DEPTH
                                                                 : int'(reg_limit);
    case (op)
      OP_EVENT: begin
        if (!reg_enable) begin
          add_status_beat(ST_IGNORED);
        end else begin
          // newest to oldest key search
          hit  = 1'b0;
          slot = ring_tail;
          if (reg_debounce != '0) begin
            for (i = 0; i < int'(ring_fill) && !hit; i++) begin
              slot = slot - 6'd1;
              if (ring_key[slot] == key) begin
                hit                 = 1'b1;
                ring_kind[slot]     = kind;
                ring_stamp[slot]    = now;
                ring_deadline[slot] = deadline;
              end
            end
          end
          if (hit) begin
            add_status_beat(ST_MERGED);
          end else begin
            status = ST_QUEUED;
            if (int'(ring_fill) >= limit && ring_fill != '0) begin
              ring_head = ring_head + 6'd1;
              ring_fill = ring_fill - 7'd1;
              status    = ST_DROPPED;
            end
            ring_key[ring_tail]      = key;
            ring_old_key[ring_tail]  = old_key;
            ring_kind[ring_tail]     = kind;
            ring_stamp[ring_tail]    = now;
            ring_deadline[ring_tail] = deadline;
            ring_tail = ring_tail + 6'd1;
            ring_fill = ring_fill + 7'd1;
            add_status_beat(status);
          end
        end
      end
      OP_POLL: begin
        // release expired entries from the head, stop at the first live one
        released = 1'b0;
        while (ring_fill != '0 && !(now < ring_deadline[ring_head])) begin
          beat.status  = ST_RELEASED;
          beat.key     = ring_key[ring_head];
          beat.old_key = ring_old_key[ring_head];
          beat.kind    = ring_kind[ring_head];
          beat.stamp   = ring_stamp[ring_head];
          ring_head    = ring_head + 6'd1;
          ring_fill    = ring_fill - 7'd1;
          beat.count   = ring_fill;
          beat.last    = !(ring_fill != '0 && !(now < ring_deadline[ring_head]));
          pending_results.push_back(beat);
          released = 1'b1;
        end
        if (!released) add_status_beat(ST_NONE_READY);
      end
      OP_CLEAR: begin
        ring_head = '0;
        ring_tail = '0;
        ring_fill = '0;
        add_status_beat(ST_CLEARED);
      end
      default: begin
        add_status_beat(ST_IGNORED);
      end
    endcase
  endfunction

  // one input beat, with a random lead-in gap
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic [PATH_KEY_W-1:0] key,
                           input logic [PATH_KEY_W-1:0] old_key,
                           input logic [KIND_W-1:0] kind,
                           input logic [TIME_W-1:0] now);
    int gap;
    @(negedge clk);
    gap = pick_gap(1'b0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_path_key     <= key;
    in_old_path_key <= old_key;
    in_event_kind   <= kind;
    in_now_ms       <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue_results(op, key, old_key, kind, now);
  endtask

  // register write, only issued with the unit idle
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_ENABLE:   reg_enable   = data[0];
      CFG_DEBOUNCE: reg_debounce = data;
      CFG_MAXQ:     reg_limit    = data[MAXQ_W-1:0];
      default:      ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold off input until every predicted beat has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // reset settings: merge, ordered release, saturation, clear, bad op
  task automatic test_merge_and_release();
    send_item(OP_EVENT, 32'h0000_0000, 32'hFFFF_FFFF, KIND_CREATED, 48'd0);
    send_item(OP_EVENT, 32'hFFFF_FFFF, 32'h0000_0000, KIND_RENAMED, 48'd5);
    send_item(OP_EVENT, 32'h0000_0000, 32'h1234_5678, KIND_MODIFIED, 48'd20);
    send_item(OP_POLL, '0, '0, KIND_CREATED, 48'd99);
    // second entry expired but stuck behind an unexpired head
    send_item(OP_POLL, '0, '0, KIND_CREATED, 48'd105);
    send_item(OP_POLL, '0, '0, KIND_CREATED, 48'd120);
    send_item(OP_POLL, '0, '0, KIND_CREATED, 48'd120);
    send_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_RENAMED, TIME_MAX);
    // deadline saturates at the top of the time range
    send_item(OP_EVENT, 32'h0000_0007, 32'hA5A5_A5A5, KIND_DELETED, TIME_MAX - 48'd50);
    send_item(OP_POLL, '0, '0, KIND_CREATED, TIME_MAX - 48'd1);
    send_item(OP_POLL, '0, '0, KIND_CREATED, TIME_MAX);
    send_item(OP_EVENT, 32'h0000_0009, 32'h0, KIND_CREATED, 48'd1000);
    send_item(OP_CLEAR, '0, '0, KIND_CREATED, '0);
  endtask

  // events ignored while disabled, polls still answered
  task automatic test_disabled_events();
    wait_results_drained();
    write_cfg(CFG_ENABLE, 32'd0);
    send_item(OP_EVENT, 32'h0000_0042, 32'h0, KIND_MODIFIED, 48'd10);
    send_item(OP_POLL, '0, '0, KIND_CREATED, TIME_MAX);
    wait_results_drained();
    write_cfg(CFG_ENABLE, 32'd1);
  endtask

  // zero debounce: duplicates queue separately and expire at once
  task automatic test_no_merge();
    wait_results_drained();
    write_cfg(CFG_DEBOUNCE, 32'd0);
    send_item(OP_EVENT, 32'h0000_0055, 32'h1, KIND_CREATED, 48'd300);
    send_item(OP_EVENT, 32'h0000_0055, 32'h2, KIND_DELETED, 48'd300);
    send_item(OP_POLL, '0, '0, KIND_CREATED, 48'd300);
  endtask

  // fill limit, then a limit lowered below the current fill
  task automatic test_queue_limit();
    wait_results_drained();
    write_cfg(CFG_MAXQ, 32'd2);
    send_item(OP_EVENT, 32'h0000_00A1, 32'h0, KIND_CREATED, 48'd400);
    send_item(OP_EVENT, 32'h0000_00B2, 32'h0, KIND_MODIFIED, 48'd401);
    send_item(OP_EVENT, 32'h0000_00C3, 32'h0, KIND_DELETED, 48'd402);
    wait_results_drained();
    write_cfg(CFG_MAXQ, 32'd1);
    send_item(OP_EVENT, 32'h0000_00D4, 32'h0, KIND_RENAMED, 48'd403);
    send_item(OP_POLL, '0, '0, KIND_CREATED, TIME_MAX);
  endtask

  // fill the whole ring, wrap it with drops, then release it in one run
  task automatic test_fill_and_wrap();
    int n;
    wait_results_drained();
    write_cfg(CFG_DEBOUNCE, 32'hFFFF_FFFF);
    write_cfg(CFG_MAXQ, 32'd64);
    for (n = 0; n < 70; n++) begin
      if (n % 25 == 24)
        send_item(OP_POLL, $urandom, $urandom, KIND_W'($urandom_range(0, 3)),
                  TIME_W'($urandom_range(0, 1000)));
      send_item(OP_EVENT, $urandom, $urandom, KIND_W'($urandom_range(0, 3)), rand_ms());
    end
    send_item(OP_POLL, $urandom, $urandom, KIND_W'($urandom_range(0, 3)), TIME_MAX);
  endtask

  // random traffic over a small key set plus noise, under three settings
  task automatic test_mixed_traffic();
    logic [PATH_KEY_W-1:0] key_set [8];
    logic [TIME_W-1:0]     clock_ms;
    logic [OP_W-1:0]       op;
    int                    phase;
    int                    counted;
    int                    roll;
    int                    k;
    for (phase = 0; phase < 3; phase++) begin
      wait_results_drained();
      case (phase)
        0: begin
          write_cfg(CFG_DEBOUNCE, 32'd20);
          write_cfg(CFG_MAXQ, 32'd0);
        end
        1: begin
          write_cfg(CFG_DEBOUNCE, 32'd0);
          write_cfg(CFG_MAXQ, 32'd5);
        end
        default: begin
          write_cfg(CFG_DEBOUNCE, $urandom_range(1, 300));
          write_cfg(CFG_MAXQ, 32'd3);
        end
      endcase
      for (k = 0; k < 8; k++) key_set[k] = $urandom;
      clock_ms = TIME_W'($urandom_range(0, 5000));
      counted  = 0;
      while (counted < 10) begin
        roll     = $urandom_range(0, 99);
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 12));
        if (roll < 55) begin
          send_item(OP_EVENT, key_set[3'($urandom_range(0, 7))], $urandom,
                    KIND_W'($urandom_range(0, 3)), clock_ms);
          counted++;
        end else if (roll < 80) begin
          send_item(OP_POLL, $urandom, $urandom, KIND_W'($urandom_range(0, 3)), clock_ms);
          counted++;
        end else if (roll < 84) begin
          send_item(OP_CLEAR, $urandom, $urandom, KIND_W'($urandom_range(0, 3)), clock_ms);
          counted++;
        end else begin
          // noise: any op code, any key, any time
          op = OP_W'($urandom_range(0, 3));
          send_item(op, $urandom, $urandom, KIND_W'($urandom_range(0, 3)), rand_ms());
          if (op != OP_RESERVED) counted++;
        end
        // now and then let the queue run dry before the next item
        if ($urandom_range(0, 24) == 0) wait_results_drained();
      end
    end
  endtask

  // stall generator on the result side
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      ready_hold = pick_gap(1'b1);
      out_ready <= (ready_hold == 0);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_beat.status  = out_status;
      got_beat.key     = out_path_key;
      got_beat.old_key = out_old_path_key;
      got_beat.kind    = out_kind;
      got_beat.stamp   = out_time;
      got_beat.last    = out_final_of_run;
      got_beat.count   = out_queued_count;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("[%0t] unexpected result beat: status %0d count %0d",
                   $realtime, out_status, out_queued_count);
      end else begin
        want_beat = pending_results.pop_front();
        if (got_beat.status !== want_beat.status || got_beat.key !== want_beat.key ||
            got_beat.old_key !== want_beat.old_key || got_beat.kind !== want_beat.kind ||
            got_beat.stamp !== want_beat.stamp || got_beat.last !== want_beat.last ||
            got_beat.count !== want_beat.count) begin
          err_count++;
          if (err_count <= 10) begin
            $display("[%0t] mismatch exp: st %0d key %h old %h kind %0d t %h last %0b cnt %0d",
                     $realtime, want_beat.status, want_beat.key, want_beat.old_key,
                     want_beat.kind, want_beat.stamp, want_beat.last, want_beat.count);
            $display("[%0t]          got: st %0d key %h old %h kind %0d t %h last %0b cnt %0d",
                     $realtime, got_beat.status, got_beat.key, got_beat.old_key,
                     got_beat.kind, got_beat.stamp, got_beat.last, got_beat.count);
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_op           = '0;
    in_path_key     = '0;
    in_old_path_key = '0;
    in_event_kind   = '0;
    in_now_ms       = '0;
    ring_head       = '0;
    ring_tail       = '0;
    ring_fill       = '0;
    reg_enable      = ENABLE_RST;
    reg_debounce    = DEBOUNCE_RST;
    reg_limit       = MAXQ_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_merge_and_release();
    test_disabled_events();
    test_no_merge();
    test_queue_limit();
    test_fill_and_wrap();
    test_mixed_traffic();

    // drain with a bound, then let any stray beat show up
    @(negedge clk);
    in_valid <= 1'b0;
    drain_guard = 0;
    while (pending_results.size() != 0 && drain_guard < 100000) begin
      @(posedge clk);
      drain_guard++;
    end
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
